FILE: rtl/xcpf_pkg.sv
`default_nettype none
package xcpf_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [7:0] START_BYTE_RST = 8'h77;
	localparam logic [7:0] END_BYTE_RST   = 8'h12;
	localparam logic [7:0] MAX_PAYLOAD    = 8'd251;
	localparam logic [7:0] OVERHEAD       = 8'd4;

	localparam logic [0:0] REG_START_BYTE = 1'b0;
	localparam logic [0:0] REG_END_BYTE   = 1'b1;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_EMPTY   = 1'b1;

	typedef struct packed {
		logic       has_head;
		logic [7:0] start;
		logic [7:0] len;
		logic       has_data;
		logic [7:0] data;
		logic       has_tail;
		logic [7:0] chk;
	} entry_t;

	typedef enum logic [4:0] {
		PH_START = 5'b00001,
		PH_LEN   = 5'b00010,
		PH_DATA  = 5'b00100,
		PH_CHK   = 5'b01000,
		PH_END   = 5'b10000
	} phase_t;

endpackage
`default_nettype wire

FILE: rtl/xcpf_front.sv
`default_nettype none
module xcpf_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output      logic                in_stall,
	input  wire logic                kind,
	input  wire logic [7:0]          data_byte,
	input  wire logic [7:0]          payload_count,
	input  wire logic [7:0]          start_byte,
	input  wire logic                q_full,
	output      logic                push,
	output      xcpf_pkg::entry_t    entry
);

	logic       in_frame_q;
	logic [7:0] bytes_left_q;
	logic [7:0] xor_q;
	logic       acc;
	logic       drop;
	logic       tail;
	logic [7:0] cnt;
	logic [7:0] left;
	logic [7:0] x;
	logic [7:0] len;

	assign in_stall = q_full;
	assign acc      = in_valid && !in_stall;
	assign drop     = (kind == xcpf_pkg::KIND_EMPTY) && in_frame_q;
	assign push     = acc && !drop;

	always_comb begin
		if (payload_count == 8'd0) begin
			cnt = 8'd1;
		end else if (payload_count > xcpf_pkg::MAX_PAYLOAD) begin
			cnt = xcpf_pkg::MAX_PAYLOAD;
		end else begin
			cnt = payload_count;
		end
		len = xcpf_pkg::OVERHEAD;
		x = xor_q;
		left = bytes_left_q;
		tail = 1'b1;
		if (kind == xcpf_pkg::KIND_EMPTY) begin
			x = start_byte ^ xcpf_pkg::OVERHEAD;
		end else if (!in_frame_q) begin
			len = cnt + xcpf_pkg::OVERHEAD;
			x = start_byte ^ len ^ data_byte;
			left = cnt - 8'd1;
			tail = (left == 8'd0);
		end else begin
			x = xor_q ^ data_byte;
			left = bytes_left_q - 8'd1;
			tail = (left == 8'd0);
		end
		entry.has_head = (kind == xcpf_pkg::KIND_EMPTY) || !in_frame_q;
		entry.start    = start_byte;
		entry.len      = len;
		entry.has_data = (kind == xcpf_pkg::KIND_PAYLOAD);
		entry.data     = data_byte;
		entry.has_tail = tail;
		entry.chk      = x;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q   <= 1'b0;
			bytes_left_q <= 8'd0;
			xor_q        <= 8'd0;
		end else if (push) begin
			in_frame_q   <= !tail;
			bytes_left_q <= tail ? 8'd0 : left;
			xor_q        <= tail ? 8'd0 : x;
		end
	end

	a_tail_closes: assert property (@(posedge clk) disable iff (!arst_n)
		push && entry.has_tail |=> !in_frame_q && bytes_left_q == 8'd0)
		else $error("frame still open after tail");
	a_open_has_left: assert property (@(posedge clk) disable iff (!arst_n)
		in_frame_q |-> bytes_left_q != 8'd0)
		else $error("open frame with no bytes left");
	a_empty_in_frame_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		acc && kind == xcpf_pkg::KIND_EMPTY && in_frame_q |-> !push)
		else $error("empty frame pushed mid-frame");

endmodule
`default_nettype wire

FILE: rtl/xcpf_queue.sv
`default_nettype none
module xcpf_queue #(
	parameter int unsigned DEPTH = xcpf_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire xcpf_pkg::entry_t wr_entry,
	input  wire logic             pop,
	output      xcpf_pkg::entry_t rd_entry,
	output      logic             full,
	output      logic             empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	xcpf_pkg::entry_t entries_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full     = (cnt_q == FULL_CNT);
	assign empty    = (cnt_q == '0);
	assign rd_entry = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("pop from empty queue");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL_CNT)
		else $error("queue count out of range");

endmodule
`default_nettype wire

FILE: rtl/xcpf_back.sv
`default_nettype none
module xcpf_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire xcpf_pkg::entry_t entry,
	input  wire logic             q_empty,
	output      logic             pop,
	input  wire logic [7:0]       end_byte,
	output      logic             out_valid,
	input  wire logic             out_stall,
	output      logic [7:0]       out_byte,
	output      logic             frame_end,
	output      logic             run_last
);

	xcpf_pkg::phase_t phase_q;
	xcpf_pkg::phase_t first_ph;
	xcpf_pkg::phase_t cur_ph;
	xcpf_pkg::phase_t nxt_ph;
	logic       busy_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       frame_end_q;
	logic       run_last_q;
	logic       load;
	logic [7:0] beat_byte;
	logic       beat_end;
	logic       beat_last;

	assign load = !q_empty && (!out_valid_q || !out_stall);
	assign pop  = load && beat_last;

	always_comb begin
		if (entry.has_head) begin
			first_ph = xcpf_pkg::PH_START;
		end else if (entry.has_data) begin
			first_ph = xcpf_pkg::PH_DATA;
		end else begin
			first_ph = xcpf_pkg::PH_CHK;
		end
		cur_ph = busy_q ? phase_q : first_ph;
		beat_byte = 8'd0;
		beat_end  = 1'b0;
		beat_last = 1'b0;
		nxt_ph    = xcpf_pkg::PH_START;
		unique case (cur_ph)
			xcpf_pkg::PH_START: begin
				beat_byte = entry.start;
				nxt_ph    = xcpf_pkg::PH_LEN;
			end
			xcpf_pkg::PH_LEN: begin
				beat_byte = entry.len;
				nxt_ph    = entry.has_data ? xcpf_pkg::PH_DATA : xcpf_pkg::PH_CHK;
			end
			xcpf_pkg::PH_DATA: begin
				beat_byte = entry.data;
				beat_last = !entry.has_tail;
				nxt_ph    = xcpf_pkg::PH_CHK;
			end
			xcpf_pkg::PH_CHK: begin
				beat_byte = entry.chk;
				nxt_ph    = xcpf_pkg::PH_END;
			end
			xcpf_pkg::PH_END: begin
				beat_byte = end_byte;
				beat_end  = 1'b1;
				beat_last = 1'b1;
			end
			default: begin
				beat_byte = 8'd0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q  <= beat_byte;
			frame_end_q <= beat_end;
			run_last_q  <= beat_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			busy_q      <= 1'b0;
			phase_q     <= xcpf_pkg::PH_START;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				busy_q      <= !beat_last;
				phase_q     <= nxt_ph;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign frame_end = frame_end_q;
	assign run_last  = run_last_q;

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && frame_end_q |-> run_last_q)
		else $error("end byte not marked as last beat");
	a_busy_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !q_empty)
		else $error("mid-entry with empty queue");
	a_phase_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(phase_q))
		else $error("phase not one-hot");
	a_pop_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		load && cur_ph == xcpf_pkg::PH_END |-> pop)
		else $error("end beat without pop");

endmodule
`default_nettype wire

FILE: rtl/xor_checksum_packet_framer_top.sv
// Frames payload bytes as start, length (payload count plus 4), payload, XOR checksum
// and end byte. Each accepted beat that is not dropped is written into a queue of
// QUEUE_DEPTH entries. The serializer sends one byte a cycle unless the queue is empty
// or the output stalls: a mid-frame payload beat sends its data, an opening beat start,
// length and data (plus checksum and end if it is the only payload byte), a closing
// beat data, checksum and end, and an empty frame start, length, checksum and end. The
// input stalls only when the queue is full. An empty-frame beat mid-frame is dropped.
`default_nettype none
module xor_checksum_packet_framer_top #(
	parameter int unsigned QUEUE_DEPTH = xcpf_pkg::QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output      logic       in_stall,
	input  wire logic       kind,
	input  wire logic [7:0] data_byte,
	input  wire logic [7:0] payload_count,
	output      logic       out_valid,
	input  wire logic       out_stall,
	output      logic [7:0] out_byte,
	output      logic       frame_end,
	output      logic       run_last,
	input  wire logic       cfg_we,
	input  wire logic [0:0] cfg_index,
	input  wire logic [7:0] cfg_data
);

	logic [7:0]       start_byte_q;
	logic [7:0]       end_byte_q;
	logic             push;
	logic             pop;
	logic             q_full;
	logic             q_empty;
	xcpf_pkg::entry_t wr_entry;
	xcpf_pkg::entry_t rd_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= xcpf_pkg::START_BYTE_RST;
			end_byte_q   <= xcpf_pkg::END_BYTE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				xcpf_pkg::REG_START_BYTE: start_byte_q <= cfg_data;
				xcpf_pkg::REG_END_BYTE:   end_byte_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	xcpf_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.kind          (kind),
		.data_byte     (data_byte),
		.payload_count (payload_count),
		.start_byte    (start_byte_q),
		.q_full        (q_full),
		.push          (push),
		.entry         (wr_entry)
	);

	xcpf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.rd_entry (rd_entry),
		.full     (q_full),
		.empty    (q_empty)
	);

	xcpf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.entry     (rd_entry),
		.q_empty   (q_empty),
		.pop       (pop),
		.end_byte  (end_byte_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.frame_end (frame_end),
		.run_last  (run_last)
	);

endmodule
`default_nettype wire
